>>> src/lruci_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lruci_pkg
// Shared sizes, types and register codes of the LRU cache with custom index.
// ---------------------------------------------------------------------------
package lruci_pkg;

  localparam int ADDR_BITS      = 32;
  localparam int MAX_INDEX_BITS = 8;
  localparam int WAYS           = 8;

  // position fields in the index position register
  localparam int POS_FIELDS = 8;
  localparam int POS_W      = 6;

  localparam int NUM_SETS   = 1 << MAX_INDEX_BITS;
  localparam int SET_W      = (MAX_INDEX_BITS > 0) ? MAX_INDEX_BITS : 1;
  localparam int IDX_LIMIT  = (MAX_INDEX_BITS < POS_FIELDS) ? MAX_INDEX_BITS : POS_FIELDS;
  localparam int RANK_W     = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int CNT_W      = $clog2(WAYS + 1);
  localparam int ADDR_IDX_W = $clog2(ADDR_BITS);

  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 48;

  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_INDEX_COUNT   = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_INDEX_POS     = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_ASSOCIATIVITY = CFG_IDX_W'(3);

  localparam logic [3:0] ASSOC_RESET = 4'd8;

  typedef struct packed {
    logic                 vld;
    logic [RANK_W-1:0]    rank;
    logic [ADDR_BITS-1:0] tag;
  } way_t;

  typedef way_t [WAYS-1:0] row_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic accept;  // capture address, read the set
    logic update;  // resolve hit/miss, write the set back, load result
  } lruci_cmd_t;

endpackage

>>> src/lruci_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lruci_ctrl
// Two-state sequencer: set read, then resolve and write back.
// ---------------------------------------------------------------------------
module lruci_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output lruci_pkg::lruci_cmd_t cmd_o
);
  import lruci_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_LOOKUP
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   out_free;

  // result slot can take a new value this cycle
  assign out_free = !out_valid_q || !out_stall_i;

  assign in_stall_o   = (state_q != ST_IDLE);
  assign out_valid_o  = out_valid_q;
  assign cmd_o.accept = (state_q == ST_IDLE) && in_valid_i;
  assign cmd_o.update = (state_q == ST_LOOKUP) && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            state_q <= ST_LOOKUP;
          end
        end
        ST_LOOKUP: begin
          if (out_free) begin
            state_q     <= ST_IDLE;
            out_valid_q <= 1'b1;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

>>> src/lruci_datapath.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lruci_datapath
// Config registers, index build, set memory and LRU update of one set.
// ---------------------------------------------------------------------------
module lruci_datapath (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [lruci_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [lruci_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  input  logic [lruci_pkg::ADDR_BITS-1:0]      address_i,
  input  lruci_pkg::lruci_cmd_t                cmd_i,
  output logic                                 hit_o
);
  import lruci_pkg::*;

  logic [4:0]                  offset_bits_q;
  logic [3:0]                  index_bit_count_q;
  logic [POS_FIELDS*POS_W-1:0] index_pos_q;
  logic [3:0]                  assoc_q;

  row_t                        mem_q [NUM_SETS];
  logic [NUM_SETS-1:0]         row_seen_q;

  row_t                        rd_row_q;
  logic                        rd_seen_q;
  logic [SET_W-1:0]            set_q;
  logic [ADDR_BITS-1:0]        tag_q;
  logic                        hit_q;

  logic [SET_W-1:0]            set_idx;
  logic [3:0]                  idx_count;
  logic [4:0]                  assoc_ext;
  logic [CNT_W-1:0]            assoc_sat;
  row_t                        cur_row;
  row_t                        new_row;
  logic                        hit;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_bits_q     <= '0;
      index_bit_count_q <= '0;
      index_pos_q       <= '0;
      assoc_q           <= ASSOC_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_OFFSET_BITS:   offset_bits_q     <= cfg_wdata_i[4:0];
        CFG_INDEX_COUNT:   index_bit_count_q <= cfg_wdata_i[3:0];
        CFG_INDEX_POS:     index_pos_q       <= cfg_wdata_i[POS_FIELDS*POS_W-1:0];
        CFG_ASSOCIATIVITY: assoc_q           <= cfg_wdata_i[3:0];
        default: ;
      endcase
    end
  end

  assign idx_count = (int'(index_bit_count_q) > IDX_LIMIT) ? 4'(IDX_LIMIT) : index_bit_count_q;

  // set index from the chosen address bits
  always_comb begin
    logic [POS_W-1:0] pos;
    set_idx = '0;
    pos     = '0;
    for (int i = 0; i < SET_W; i++) begin
      if (i < POS_FIELDS) begin
        pos = index_pos_q[POS_W*i +: POS_W];
        if ((i < int'(idx_count)) && (int'(pos) < ADDR_BITS)) begin
          set_idx[i] = address_i[pos[ADDR_IDX_W-1:0]];
        end
      end
    end
  end

  // row flags stand in for clearing the memory at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_seen_q <= '0;
    end else if (cmd_i.update) begin
      row_seen_q[set_q] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      rd_row_q  <= mem_q[set_idx];
      rd_seen_q <= row_seen_q[set_idx];
      set_q     <= set_idx;
      tag_q     <= address_i >> offset_bits_q;
    end
    if (cmd_i.update) begin
      mem_q[set_q] <= new_row;
      hit_q        <= hit;
    end
  end

  assign assoc_ext = {1'b0, assoc_q};
  assign assoc_sat = (assoc_ext == 5'd0)        ? CNT_W'(1) :
                     (int'(assoc_ext) > WAYS)   ? CNT_W'(WAYS) :
                                                  CNT_W'(assoc_ext);

  // hit/miss resolution and new LRU state of the set
  always_comb begin
    logic [WAYS-1:0]   match;
    logic [WAYS-1:0]   kept;
    logic [RANK_W-1:0] hit_way;
    logic [RANK_W-1:0] hit_rank;
    logic [RANK_W-1:0] free_way;
    logic [CNT_W-1:0]  n_valid;
    logic              evict;
    cur_row  = rd_row_q;
    match    = '0;
    kept     = '0;
    hit_way  = '0;
    hit_rank = '0;
    free_way = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (!rd_seen_q) begin
        cur_row[w].vld = 1'b0;
      end
    end
    for (int w = 0; w < WAYS; w++) begin
      match[w] = cur_row[w].vld && (cur_row[w].tag == tag_q);
    end
    hit = |match;
    // lowest matching way wins
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (match[w]) begin
        hit_way  = RANK_W'(w);
        hit_rank = cur_row[w].rank;
      end
    end
    n_valid = '0;
    for (int w = 0; w < WAYS; w++) begin
      n_valid = n_valid + CNT_W'(cur_row[w].vld);
    end
    evict   = (n_valid >= assoc_sat);
    new_row = cur_row;
    if (hit) begin
      for (int w = 0; w < WAYS; w++) begin
        if (cur_row[w].vld && (cur_row[w].rank < hit_rank)) begin
          new_row[w].rank = cur_row[w].rank + RANK_W'(1);
        end
      end
      new_row[hit_way].rank = '0;
    end else begin
      // eviction keeps only entries more recent than associativity - 1
      for (int w = 0; w < WAYS; w++) begin
        kept[w] = cur_row[w].vld &&
                  !(evict && (CNT_W'(cur_row[w].rank) >= (assoc_sat - CNT_W'(1))));
      end
      for (int w = WAYS - 1; w >= 0; w--) begin
        if (!kept[w]) begin
          free_way = RANK_W'(w);
        end
      end
      for (int w = 0; w < WAYS; w++) begin
        new_row[w].vld = kept[w];
        if (kept[w]) begin
          new_row[w].rank = cur_row[w].rank + RANK_W'(1);
        end
      end
      new_row[free_way].vld  = 1'b1;
      new_row[free_way].rank = '0;
      new_row[free_way].tag  = tag_q;
    end
  end

  assign hit_o = hit_q;

endmodule

>>> src/lru_cache_custom_index.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lru_cache_custom_index
// Set-associative cache hit/miss tracker, true LRU, software-chosen index bits.
// ---------------------------------------------------------------------------
// Usage:
//   input channel  : in_valid_i / in_stall_o with address_i, one reference
//   output channel : out_valid_o / out_stall_i with hit_o, one result each
//   config port    : cfg_we_i, cfg_idx_i, cfg_wdata_i; write only while idle
// Each reference passes a read step and a resolve step: the first reads the whole set
// from the set memory, the second resolves hit/miss, writes the set back and loads the
// result register. The set memory is read and written through one port, so
// the input stalls in the resolve step, until the last reference is done.
// out_valid_o goes high when the resolve step loads the result register.
// A finished result waits in the output register while the next reference
// is read; if the receiver still stalls, the block holds in the resolve
// step and stalls its input until the result register frees up.
// Reset clears the config to its defaults and marks every set empty through
// one flag per set, so no clearing pass is needed and traffic starts at once.
// ---------------------------------------------------------------------------
module lru_cache_custom_index (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [lruci_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [lruci_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [lruci_pkg::ADDR_BITS-1:0]  address_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic                             hit_o
);
  import lruci_pkg::*;

  lruci_cmd_t cmd;

  lruci_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  lruci_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .address_i   (address_i),
    .cmd_i       (cmd),
    .hit_o       (hit_o)
  );

endmodule
